[rtl/core/wf_pkg.sv]
// ----------------------------------------------------------------------------
// wf_pkg: shared constants for the waypoint follower
// Field widths, request and status codes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package wf_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int RAD_W      = 23;
  localparam int SPD_W      = 16;
  localparam int HEAD_W     = 16;
  localparam int STAT_W     = 3;
  localparam int TI_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int CX_W       = 28;
  localparam int Z_W        = 34;
  localparam int ATAN_IDX_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd2;

  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd0;
  localparam logic [STAT_W-1:0] ST_SETPOINT = 3'd1;
  localparam logic [STAT_W-1:0] ST_ADVANCED = 3'd2;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_STORED   = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURGE_SPEED   = 2'd1;

  localparam logic [RAD_W-1:0] RADIUS_RST = 23'd256;
  localparam logic [SPD_W-1:0] SURGE_RST  = 16'd128;

  localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 34'sd843314856;
  localparam logic signed [Z_W-1:0] HEAD_LIMIT  = 34'sd25736;
  localparam logic signed [Z_W-1:0] ROUND_HALF  = 34'sd32768;

  function automatic logic signed [Z_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sd421657428;
      5'd1:    v = 34'sd248918915;
      5'd2:    v = 34'sd131521918;
      5'd3:    v = 34'sd66762579;
      5'd4:    v = 34'sd33510843;
      5'd5:    v = 34'sd16771758;
      5'd6:    v = 34'sd8387925;
      5'd7:    v = 34'sd4194219;
      5'd8:    v = 34'sd2097141;
      5'd9:    v = 34'sd1048575;
      5'd10:   v = 34'sd524288;
      5'd11:   v = 34'sd262144;
      5'd12:   v = 34'sd131072;
      5'd13:   v = 34'sd65536;
      5'd14:   v = 34'sd32768;
      5'd15:   v = 34'sd16384;
      5'd16:   v = 34'sd8192;
      5'd17:   v = 34'sd4096;
      5'd18:   v = 34'sd2048;
      5'd19:   v = 34'sd1024;
      5'd20:   v = 34'sd512;
      5'd21:   v = 34'sd256;
      5'd22:   v = 34'sd128;
      5'd23:   v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wf_ram.sv]
// ----------------------------------------------------------------------------
// wf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/waypoint_follower.sv]
// ----------------------------------------------------------------------------
// waypoint_follower: acceptance-radius waypoint follower
// Stores 2-D waypoints, tests position samples against the current waypoint
// and returns a CORDIC atan2 bearing and surge set point.
// ----------------------------------------------------------------------------
// Timing: append, replace and empty-table samples go from the transfer straight
// to S_EMIT; other samples pass S_LOAD, S_SQX, S_SQY, S_SQR and S_CMP, and those
// outside the radius then S_ROT and S_FIN, using the shared squaring multiplier
// (3 passes) and the iterative CORDIC stage. S_EMIT loads the output register.
// Throughput: one item at a time; the next transfer is taken once the result
// is in the output register. Reset clears table count, cursor, output valid and
// the state machine and loads the register defaults; no clearing pass is run.
`default_nettype none

module waypoint_follower #(
  parameter int MAX_WAYPOINTS = wf_pkg::MAX_WAYPOINTS_DEF,
  parameter int CORDIC_STEPS  = wf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [wf_pkg::FUNC_W-1:0]       func_i,
  input  wire logic signed [wf_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic signed [wf_pkg::COORD_W-1:0] coord_y_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [wf_pkg::STAT_W-1:0]            status_o,
  output logic signed [wf_pkg::HEAD_W-1:0]     heading_o,
  output logic [wf_pkg::SPD_W-1:0]             surge_cmd_o,
  output logic [wf_pkg::TI_W-1:0]              target_index_o
);

  localparam int IDX_W  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam int WPT_W  = 2 * wf_pkg::COORD_W;
  localparam int PROD_W = 2 * wf_pkg::DIFF_W;
  localparam int D2_W   = PROD_W + 1;
  localparam int TI_W   = wf_pkg::TI_W;
  localparam int AI_W   = wf_pkg::ATAN_IDX_W;
  localparam int CX_W   = wf_pkg::CX_W;
  localparam int Z_W    = wf_pkg::Z_W;
  localparam int DIFF_W = wf_pkg::DIFF_W;
  localparam int COORD_W = wf_pkg::COORD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_SQR  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_ROT  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]                        state_q, state_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [IDX_W-1:0]                  cursor_q, cursor_d;
  logic [wf_pkg::RAD_W-1:0]          radius_q, radius_d;
  logic [wf_pkg::SPD_W-1:0]          surge_q, surge_d;
  logic signed [COORD_W-1:0]         px_q, px_d, py_q, py_d;
  logic signed [DIFF_W-1:0]          dx_q, dx_d, dy_q, dy_d;
  logic signed [PROD_W-1:0]          mul_q, mul_d;
  logic [D2_W-1:0]                   d2_q, d2_d;
  logic signed [CX_W-1:0]            cx_q, cx_d, cy_q, cy_d;
  logic signed [Z_W-1:0]             z_q, z_d;
  logic [ITER_W-1:0]                 iter_q, iter_d;
  logic                              zero_q, zero_d;
  logic [wf_pkg::STAT_W-1:0]         res_stat_q, res_stat_d;
  logic signed [wf_pkg::HEAD_W-1:0]  res_head_q, res_head_d;
  logic [wf_pkg::SPD_W-1:0]          res_surge_q, res_surge_d;
  logic                              out_valid_q, out_valid_d;
  logic [wf_pkg::STAT_W-1:0]         out_stat_q, out_stat_d;
  logic signed [wf_pkg::HEAD_W-1:0]  out_head_q, out_head_d;
  logic [wf_pkg::SPD_W-1:0]          out_surge_q, out_surge_d;
  logic [TI_W-1:0]                   out_ti_q, out_ti_d;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  logic [WPT_W-1:0]                  ram_rdata;
  logic signed [COORD_W-1:0]         wx, wy;
  logic signed [DIFF_W-1:0]          mul_a, mul_b;
  logic signed [PROD_W-1:0]          mul_prod;
  logic                              in_fire, emit_fire;
  logic [CNT_W-1:0]                  nxt_idx;
  logic signed [CX_W-1:0]            dx_e, dy_e, xs, ys;
  logic [ITER_W+AI_W-1:0]            iter_ext;
  logic signed [Z_W-1:0]             atan_v, z_rnd;
  logic [IDX_W+TI_W-1:0]             cur_ext;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign emit_fire      = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign heading_o      = out_head_q;
  assign surge_cmd_o    = out_surge_q;
  assign target_index_o = out_ti_q;

  wf_ram #(
    .WIDTH (WPT_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_wpt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({coord_x_i, coord_y_i}),
    .raddr_i (cursor_q),
    .rdata_o (ram_rdata)
  );

  assign wx = ram_rdata[WPT_W-1:COORD_W];
  assign wy = ram_rdata[COORD_W-1:0];

  // shared squaring multiplier
  always_comb begin
    unique case (state_q)
      S_SQX:   begin mul_a = dx_q; mul_b = dx_q; end
      S_SQY:   begin mul_a = dy_q; mul_b = dy_q; end
      default: begin
        mul_a = $signed({2'b00, radius_q});
        mul_b = $signed({2'b00, radius_q});
      end
    endcase
  end
  assign mul_prod = mul_a * mul_b;

  assign nxt_idx  = {{(CNT_W-IDX_W){1'b0}}, cursor_q} + CNT_W'(1);
  assign dx_e     = CX_W'(dx_q);
  assign dy_e     = CX_W'(dy_q);
  assign xs       = cx_q >>> iter_q;
  assign ys       = cy_q >>> iter_q;
  assign iter_ext = {{AI_W{1'b0}}, iter_q};
  assign atan_v   = wf_pkg::atan_q29(iter_ext[AI_W-1:0]);
  assign z_rnd    = (z_q + wf_pkg::ROUND_HALF) >>> 16;
  assign cur_ext  = {{TI_W{1'b0}}, cursor_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    radius_d    = radius_q;
    surge_d     = surge_q;
    px_d        = px_q;
    py_d        = py_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    mul_d       = mul_prod;
    d2_d        = d2_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    z_d         = z_q;
    iter_d      = iter_q;
    zero_d      = zero_q;
    res_stat_d  = res_stat_q;
    res_head_d  = res_head_q;
    res_surge_d = res_surge_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_head_d  = out_head_q;
    out_surge_d = out_surge_q;
    out_ti_d    = out_ti_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IDX_W-1:0];

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wf_pkg::REG_ACCEPT_RADIUS: radius_d = cfg_data_i[wf_pkg::RAD_W-1:0];
        wf_pkg::REG_SURGE_SPEED:   surge_d  = cfg_data_i[wf_pkg::SPD_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          px_d        = coord_x_i;
          py_d        = coord_y_i;
          res_head_d  = '0;
          res_surge_d = '0;
          state_d     = S_EMIT;
          case (func_i)
            wf_pkg::FUNC_APPEND: begin
              if (count_q < CNT_W'(MAX_WAYPOINTS)) begin
                ram_we     = 1'b1;
                count_d    = count_q + CNT_W'(1);
                res_stat_d = wf_pkg::ST_STORED;
              end else begin
                res_stat_d = wf_pkg::ST_FULL;
              end
            end
            wf_pkg::FUNC_REPLACE: begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              count_d    = CNT_W'(1);
              cursor_d   = '0;
              res_stat_d = wf_pkg::ST_STORED;
            end
            default: begin
              if (count_q == '0) begin
                res_stat_d = wf_pkg::ST_EMPTY;
              end else begin
                state_d = S_LOAD;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        dx_d    = DIFF_W'(wx) - DIFF_W'(px_q);
        dy_d    = DIFF_W'(wy) - DIFF_W'(py_q);
        state_d = S_SQX;
      end
      S_SQX: state_d = S_SQY;
      S_SQY: begin
        d2_d    = D2_W'(unsigned'(mul_q));
        state_d = S_SQR;
      end
      S_SQR: begin
        d2_d    = d2_q + D2_W'(unsigned'(mul_q));
        state_d = S_CMP;
      end
      S_CMP: begin
        // mul_q holds radius squared here
        if (d2_q < D2_W'(unsigned'(mul_q))) begin
          if (nxt_idx >= count_q) begin
            cursor_d   = '0;
            res_stat_d = wf_pkg::ST_DONE;
          end else begin
            cursor_d   = nxt_idx[IDX_W-1:0];
            res_stat_d = wf_pkg::ST_ADVANCED;
          end
          state_d = S_EMIT;
        end else begin
          zero_d = (dx_q == '0) && (dy_q == '0);
          iter_d = '0;
          if (!dx_q[DIFF_W-1]) begin
            cx_d = dx_e;
            cy_d = dy_e;
            z_d  = '0;
          end else if (!dy_q[DIFF_W-1]) begin
            cx_d = dy_e;
            cy_d = -dx_e;
            z_d  = wf_pkg::HALF_PI_Q29;
          end else begin
            cx_d = -dy_e;
            cy_d = dx_e;
            z_d  = -wf_pkg::HALF_PI_Q29;
          end
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        if (!cy_q[CX_W-1]) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          z_d  = z_q + atan_v;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          z_d  = z_q - atan_v;
        end
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (zero_q) begin
          res_head_d = '0;
        end else if (z_rnd > wf_pkg::HEAD_LIMIT) begin
          res_head_d = wf_pkg::HEAD_LIMIT[wf_pkg::HEAD_W-1:0];
        end else if (z_rnd < -wf_pkg::HEAD_LIMIT) begin
          res_head_d = -wf_pkg::HEAD_LIMIT[wf_pkg::HEAD_W-1:0];
        end else begin
          res_head_d = z_rnd[wf_pkg::HEAD_W-1:0];
        end
        res_surge_d = surge_q;
        res_stat_d  = wf_pkg::ST_SETPOINT;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_head_d  = res_head_q;
          out_surge_d = res_surge_q;
          out_ti_d    = cur_ext[TI_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      radius_q    <= wf_pkg::RADIUS_RST;
      surge_q     <= wf_pkg::SURGE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      radius_q    <= radius_d;
      surge_q     <= surge_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q        <= px_d;
    py_q        <= py_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    mul_q       <= mul_d;
    d2_q        <= d2_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    z_q         <= z_d;
    iter_q      <= iter_d;
    zero_q      <= zero_d;
    res_stat_q  <= res_stat_d;
    res_head_q  <= res_head_d;
    res_surge_q <= res_surge_d;
    out_stat_q  <= out_stat_d;
    out_head_q  <= out_head_d;
    out_surge_q <= out_surge_d;
    out_ti_q    <= out_ti_d;
  end

  a_cursor_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> {{(CNT_W-IDX_W){1'b0}}, cursor_q} < count_q)
    else $error("cursor beyond stored waypoints");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_WAYPOINTS))
    else $error("waypoint count overflow");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("input taken without starting work");

  a_unused_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q != wf_pkg::ST_SETPOINT |-> out_head_q == '0 && out_surge_q == '0)
    else $error("heading or surge set outside set point result");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_valid_q && state_q == S_IDLE)
    else $error("result not moved to output register");

endmodule

`default_nettype wire

[bench/wf_guidance_check.sv]
// ----------------------------------------------------------------------------
// wf_guidance_check: result checker for the waypoint follower
// Watches the config, request and result channels, keeps its own copy of the
// waypoint table, cursor and registers, and compares every result transfer
// with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wf_guidance_check (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [wf_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [wf_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [wf_pkg::FUNC_W-1:0]             func_i,
  input  logic signed [wf_pkg::COORD_W-1:0]     coord_x_i,
  input  logic signed [wf_pkg::COORD_W-1:0]     coord_y_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [wf_pkg::STAT_W-1:0]             status_i,
  input  logic signed [wf_pkg::HEAD_W-1:0]      heading_i,
  input  logic [wf_pkg::SPD_W-1:0]              surge_cmd_i,
  input  logic [wf_pkg::TI_W-1:0]               target_index_i,
  output int                                    outstanding_o,
  output int                                    errors_o
);
  import wf_pkg::*;

  localparam int     WPT_DEPTH    = MAX_WAYPOINTS_DEF;
  localparam int     ATAN_STEPS   = CORDIC_STEPS_DEF;
  localparam longint QUARTER_TURN = 64'sd843314856;
  localparam longint HEADING_CAP  = 64'sd25736;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HEAD_W-1:0] heading;
    logic [SPD_W-1:0]  surge_cmd;
    logic [TI_W-1:0]   target_index;
  } guidance_t;

  logic signed [COORD_W-1:0] wpt_x [WPT_DEPTH];
  logic signed [COORD_W-1:0] wpt_y [WPT_DEPTH];
  logic [6:0]                wpt_count;
  logic [TI_W-1:0]           wpt_cursor;
  logic [RAD_W-1:0]          radius;
  logic [SPD_W-1:0]          surge_speed;
  longint                    arctan_q29 [24];
  guidance_t                 pending_guidance [$];
  int                        errors = 0;

  initial begin
    int k;
    outstanding_o = 0;
    errors_o = 0;
    for (k = 0; k < 24; k++) begin
      arctan_q29[k] = longint'($rtoi($atan(1.0 / (2.0 ** k)) * 536870912.0 + 0.5));
    end
  end

  // vectoring CORDIC, angle kept in Q2.29, result in Q2.13
  function automatic logic [HEAD_W-1:0] bearing_q13(input longint dy, input longint dx);
    longint x, y, z, t, xs, ys;
    int     i;
    if (dx == 0 && dy == 0) return '0;
    x = dx;
    y = dy;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t; z = -QUARTER_TURN;
      end
    end
    for (i = 0; i < ATAN_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + arctan_q29[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_q29[i];
      end
    end
    z = (z + 32768) >>> 16;
    if (z > HEADING_CAP) z = HEADING_CAP;
    if (z < -HEADING_CAP) z = -HEADING_CAP;
    return HEAD_W'(z);
  endfunction

  function automatic guidance_t follow_waypoint(input logic [FUNC_W-1:0] f,
                                                input logic signed [COORD_W-1:0] px,
                                                input logic signed [COORD_W-1:0] py);
    guidance_t g;
    longint    dx, dy, d2, r2;
    int        idx;
    g = '0;
    if (f == FUNC_APPEND) begin
      if (wpt_count < WPT_DEPTH) begin
        wpt_x[wpt_count[5:0]] = px;
        wpt_y[wpt_count[5:0]] = py;
        wpt_count = wpt_count + 7'd1;
        g.status = ST_STORED;
      end else begin
        g.status = ST_FULL;
      end
    end else if (f == FUNC_REPLACE) begin
      wpt_x[0] = px;
      wpt_y[0] = py;
      wpt_count = 7'd1;
      wpt_cursor = '0;
      g.status = ST_STORED;
    end else if (wpt_count == 0) begin
      g.status = ST_EMPTY;
    end else begin
      idx = (wpt_cursor < wpt_count) ? int'(wpt_cursor) : 0;
      dx = longint'(wpt_x[idx]) - longint'(px);
      dy = longint'(wpt_y[idx]) - longint'(py);
      d2 = dx * dx + dy * dy;
      r2 = longint'(radius) * longint'(radius);
      if (d2 < r2) begin
        idx++;
        if (idx >= int'(wpt_count)) begin
          wpt_cursor = '0;
          g.status = ST_DONE;
        end else begin
          wpt_cursor = TI_W'(idx);
          g.status = ST_ADVANCED;
        end
      end else begin
        wpt_cursor = TI_W'(idx);
        g.heading = bearing_q13(dy, dx);
        g.surge_cmd = surge_speed;
        g.status = ST_SETPOINT;
      end
    end
    g.target_index = wpt_cursor;
    return g;
  endfunction

  always @(posedge clk_i) begin : watch
    guidance_t want;
    if (!rst_ni) begin
      wpt_count = '0;
      wpt_cursor = '0;
      radius = RADIUS_RST;
      surge_speed = SURGE_RST;
      pending_guidance.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_guidance.size() == 0) begin
          $error("result transfer with nothing pending: status %0d", status_i);
          errors++;
        end else begin
          want = pending_guidance.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errors++;
          end
          if (heading_i !== want.heading) begin
            $error("heading: expected %0d, got %0d", $signed(want.heading), heading_i);
            errors++;
          end
          if (surge_cmd_i !== want.surge_cmd) begin
            $error("surge_cmd: expected %0d, got %0d", want.surge_cmd, surge_cmd_i);
            errors++;
          end
          if (target_index_i !== want.target_index) begin
            $error("target_index: expected %0d, got %0d", want.target_index,
                   target_index_i);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ACCEPT_RADIUS: radius = cfg_data_i[RAD_W-1:0];
          REG_SURGE_SPEED:   surge_speed = cfg_data_i[SPD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_guidance.push_back(follow_waypoint(func_i, coord_x_i, coord_y_i));
      end
    end
    outstanding_o <= pending_guidance.size();
    errors_o <= errors;
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for the waypoint follower
// Directed requests cover the empty table, field extremes, the radius
// boundary, zero-length and axis bearings and register extremes; random
// missions then replace and fill the table, walk it with misses and hits
// and hit the full-table drop, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import wf_pkg::*;

  localparam logic [FUNC_W-1:0]    FUNC_SAMPLE_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B     = 2'd3;
  localparam longint COORD_MAX    = 64'sd8388607;
  localparam longint COORD_MIN    = -64'sd8388608;
  localparam int     ITEM_GOAL    = 1625;
  localparam int     CALM_AFTER   = 1425;
  localparam int     PHASE_ITEMS  = 200;
  localparam int     QUIET_LIMIT  = 3000;
  localparam int     DRAIN_CYCLES = 60;

  logic                      clk;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func = FUNC_SAMPLE;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STAT_W-1:0]         status;
  logic signed [HEAD_W-1:0]  heading;
  logic [SPD_W-1:0]          surge_cmd;
  logic [TI_W-1:0]           target_index;
  int                        outstanding;
  int                        errors;

  int               sent = 0;
  bit               calm = 1'b0;
  int               gap_odds = 3;
  int               stall_odds = 3;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  logic [RAD_W-1:0] cur_radius = RADIUS_RST;
  longint           wp_x [MAX_WAYPOINTS_DEF];
  longint           wp_y [MAX_WAYPOINTS_DEF];
  int               wp_count = 0;

  waypoint_follower dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .heading_o      (heading),
    .surge_cmd_o    (surge_cmd),
    .target_index_o (target_index)
  );

  wf_guidance_check u_check (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .heading_i      (heading),
    .surge_cmd_i    (surge_cmd),
    .target_index_i (target_index),
    .outstanding_o  (outstanding),
    .errors_o       (errors)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(1, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni;
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("waypoint_follower regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    if (v < COORD_MIN) return COORD_W'(COORD_MIN);
    return COORD_W'(v);
  endfunction

  function automatic longint rand_coord();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    case ($urandom_range(0, 9))
      0:          return COORD_MAX;
      1:          return COORD_MIN;
      2, 3, 4, 5: return longint'($signed(v[12:0]));
      default:    return longint'(v);
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] sample_code();
    return ($urandom_range(0, 4) == 0) ? FUNC_SAMPLE_ALT : FUNC_SAMPLE;
  endfunction

  // valid is left high after the transfer; the next call or settle() moves it
  task automatic push_item(input logic [FUNC_W-1:0] f, input longint x, input longint y);
    logic signed [COORD_W-1:0] sx, sy;
    sx = sat_coord(x);
    sy = sat_coord(y);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    coord_x <= sx;
    coord_y <= sy;
    do @(posedge clk); while (!in_ready);
    sent++;
    calm = (sent >= CALM_AFTER);
    if (f == FUNC_REPLACE) begin
      wp_x[0] = sx;
      wp_y[0] = sy;
      wp_count = 1;
    end else if (f == FUNC_APPEND && wp_count < MAX_WAYPOINTS_DEF) begin
      wp_x[wp_count] = sx;
      wp_y[wp_count] = sy;
      wp_count++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [RAD_W-1:0] radius, input logic [SPD_W-1:0] speed,
                          input bit spare);
    settle();
    write_reg(REG_ACCEPT_RADIUS, radius);
    write_reg(REG_SURGE_SPEED, {7'($urandom), speed});
    if (spare) write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                         CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cur_radius = radius;
  endtask

  task automatic retune();
    logic [RAD_W-1:0] radius;
    logic [SPD_W-1:0] speed;
    case ($urandom_range(0, 5))
      0:       radius = '0;
      1:       radius = '1;
      2:       radius = RAD_W'($urandom_range(1, 16));
      3:       radius = RAD_W'($urandom_range(17, 4095));
      4:       radius = RAD_W'($urandom_range(4096, 65535));
      default: radius = RAD_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       speed = '0;
      1:       speed = '1;
      default: speed = SPD_W'($urandom);
    endcase
    set_regs(radius, speed, $urandom_range(0, 1) == 1);
    gap_odds = 4 * $urandom_range(0, 3);
    stall_odds = 4 * $urandom_range(0, 3);
  endtask

  // replace, append, then walk the table in order: a few misses, then a sample aimed inside the radius
  task automatic fly_mission();
    int     legs, leg, tries, k;
    longint r, ox, oy;
    legs = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 70))
                                        : int'($urandom_range(1, 6));
    push_item(FUNC_REPLACE, rand_coord(), rand_coord());
    for (k = 1; k < legs; k++) push_item(FUNC_APPEND, rand_coord(), rand_coord());
    r = longint'(cur_radius);
    for (leg = 0; leg < wp_count; leg++) begin
      for (tries = $urandom_range(0, 2); tries > 0; tries--) begin
        if ($urandom_range(0, 1) == 1) begin
          push_item(sample_code(), rand_coord(), rand_coord());
        end else begin
          // on the acceptance circle, not inside it
          ox = ($urandom_range(0, 1) == 1) ? r : -r;
          if ($urandom_range(0, 1) == 1) push_item(sample_code(), wp_x[leg] + ox, wp_y[leg]);
          else push_item(sample_code(), wp_x[leg], wp_y[leg] + ox);
        end
      end
      if ($urandom_range(0, 15) == 0)
        push_item(FUNC_W'($urandom_range(0, 3)), rand_coord(), rand_coord());
      if ($urandom_range(0, 20) == 0) break;
      case ($urandom_range(0, 2))
        0: begin
          ox = r - 1;
          oy = 0;
          if ($urandom_range(0, 1) == 1) begin
            oy = ox;
            ox = 0;
          end
        end
        1: begin
          ox = longint'($urandom_range(0, 32'(r / 2)));
          oy = longint'($urandom_range(0, 32'(r / 2)));
        end
        default: begin
          ox = 0;
          oy = 0;
        end
      endcase
      if ($urandom_range(0, 1) == 1) ox = -ox;
      if ($urandom_range(0, 1) == 1) oy = -oy;
      push_item(sample_code(), wp_x[leg] + ox, wp_y[leg] + oy);
    end
  endtask

  initial begin
    int phase_end;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_SAMPLE_ALT, 5, -5);
    push_item(FUNC_REPLACE, 100, 200);
    push_item(FUNC_SAMPLE, 100, 200);
    push_item(FUNC_APPEND, COORD_MAX, COORD_MAX);
    push_item(FUNC_APPEND, COORD_MIN, COORD_MIN);
    push_item(FUNC_SAMPLE, COORD_MIN, COORD_MAX);
    push_item(FUNC_SAMPLE, 355, 200);
    push_item(FUNC_SAMPLE, COORD_MIN, COORD_MIN);
    push_item(FUNC_SAMPLE_ALT, COORD_MAX, COORD_MAX);
    push_item(FUNC_SAMPLE, COORD_MAX, COORD_MIN);
    push_item(FUNC_SAMPLE, COORD_MAX, COORD_MAX);
    push_item(FUNC_SAMPLE, COORD_MIN + 256, COORD_MIN);
    push_item(FUNC_SAMPLE, COORD_MIN, COORD_MIN);

    set_regs('0, '1, 1'b0);
    push_item(FUNC_SAMPLE, 100, 200);
    push_item(FUNC_SAMPLE, 100, 201);
    push_item(FUNC_SAMPLE, 100, 199);
    push_item(FUNC_SAMPLE, 99, 200);
    push_item(FUNC_SAMPLE_ALT, 101, 200);

    set_regs('1, '0, 1'b1);
    push_item(FUNC_SAMPLE, COORD_MIN, COORD_MIN);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_REPLACE, COORD_MIN, COORD_MAX);
    push_item(FUNC_APPEND, 0, 0);
    push_item(FUNC_APPEND, -1, 1);

    phase_end = 0;
    while (sent < ITEM_GOAL) begin
      if (sent >= phase_end) begin
        retune();
        phase_end = sent + PHASE_ITEMS;
      end
      if ($urandom_range(0, 5) == 0)
        push_item(FUNC_W'($urandom_range(0, 3)), rand_coord(), rand_coord());
      else
        fly_mission();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("waypoint_follower regression: pass");
    end else begin
      $display("waypoint_follower regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/wf_pkg.sv
rtl/core/wf_ram.sv
rtl/core/waypoint_follower.sv
bench/wf_guidance_check.sv
bench/tb.sv
